[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros shared by the header cipher modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PHCC_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PHCC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[src/phcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phcc_pkg
// shared types and constants of the packet header chained cipher
// ----------------------------------------------------------------------------
package phcc_pkg;

    // item field widths
    localparam int CMD_W  = 2;
    localparam int DATA_W = 8;
    localparam int POS_W  = 16;

    // key storage
    localparam int KEY_WORDS     = 5;
    localparam int KEY_WORD_W    = 64;
    localparam int IDX_W         = 6;
    localparam int WSEL_W        = 3;
    localparam int BSEL_W        = 3;
    localparam int MAX_KEY_BYTES = 40;

    // header sizes
    localparam logic [POS_W-1:0] SEND_HEADER_BYTES = 16'd6;
    localparam logic [POS_W-1:0] RECV_HEADER_BYTES = 16'd4;

    // remainder unit: one restoring step per bit of the key index
    localparam int MOD_STEPS = IDX_W;
    localparam int SHIFT_W   = $clog2(MOD_STEPS);
    localparam int DIV_W     = IDX_W + MOD_STEPS - 1;

    // commands
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEND    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RECV    = 2'd2;

    // configuration port
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;
    localparam int REG_IDX_W  = 3;
    localparam logic [REG_IDX_W-1:0] REG_KEY_LENGTH = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KEY_WORD_0 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KEY_WORD_1 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KEY_WORD_2 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_KEY_WORD_3 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_KEY_WORD_4 = 3'd5;

    // configuration seen by the datapath
    typedef struct packed {
        logic [IDX_W-1:0]                         key_length;
        logic [KEY_WORDS-1:0][KEY_WORD_W-1:0]     key_words;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic               capture;
        logic               mod_step;
        logic [SHIFT_W-1:0] mod_shift;
        logic               emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_mod;
        logic out_free;
    } t_dp_status;

endpackage

[src/phcc_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phcc_in_if
// input item channel: command, packet byte, position and packet length
// ----------------------------------------------------------------------------
interface phcc_in_if;
    logic                            valid;
    logic                            ready;
    logic [phcc_pkg::CMD_W-1:0]      command;
    logic [phcc_pkg::DATA_W-1:0]     data_in;
    logic [phcc_pkg::POS_W-1:0]      byte_index;
    logic [phcc_pkg::POS_W-1:0]      packet_length;

    modport source (output valid, command, data_in, byte_index, packet_length, input ready);
    modport sink   (input valid, command, data_in, byte_index, packet_length, output ready);
endinterface

[src/phcc_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phcc_out_if
// result item channel: output byte and transformed flag
// ----------------------------------------------------------------------------
interface phcc_out_if;
    logic                        valid;
    logic                        ready;
    logic [phcc_pkg::DATA_W-1:0] data_out;
    logic                        transformed;

    modport source (output valid, data_out, transformed, input ready);
    modport sink   (input valid, data_out, transformed, output ready);
endinterface

[src/phcc_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phcc_regs
// apb register file: key length and five 64-bit key words
// ----------------------------------------------------------------------------
module phcc_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [phcc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [phcc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [phcc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output phcc_pkg::t_cfg                      o_cfg
);

    logic [phcc_pkg::REG_IDX_W-1:0]   reg_idx;
    logic                             wr_en;
    logic [phcc_pkg::IDX_W-1:0]       r_key_length;
    logic [phcc_pkg::KEY_WORD_W-1:0]  r_key_word_0;
    logic [phcc_pkg::KEY_WORD_W-1:0]  r_key_word_1;
    logic [phcc_pkg::KEY_WORD_W-1:0]  r_key_word_2;
    logic [phcc_pkg::KEY_WORD_W-1:0]  r_key_word_3;
    logic [phcc_pkg::KEY_WORD_W-1:0]  r_key_word_4;

    // registers sit on 8-byte boundaries
    assign reg_idx = paddr[phcc_pkg::APB_ADDR_W-1 -: phcc_pkg::REG_IDX_W];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= phcc_pkg::IDX_W'(1);
            r_key_word_0 <= '0;
            r_key_word_1 <= '0;
            r_key_word_2 <= '0;
            r_key_word_3 <= '0;
            r_key_word_4 <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                phcc_pkg::REG_KEY_LENGTH: r_key_length <= pwdata[phcc_pkg::IDX_W-1:0];
                phcc_pkg::REG_KEY_WORD_0: r_key_word_0 <= pwdata;
                phcc_pkg::REG_KEY_WORD_1: r_key_word_1 <= pwdata;
                phcc_pkg::REG_KEY_WORD_2: r_key_word_2 <= pwdata;
                phcc_pkg::REG_KEY_WORD_3: r_key_word_3 <= pwdata;
                phcc_pkg::REG_KEY_WORD_4: r_key_word_4 <= pwdata;
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (reg_idx)
            phcc_pkg::REG_KEY_LENGTH:
                prdata = {{(phcc_pkg::APB_DATA_W-phcc_pkg::IDX_W){1'b0}}, r_key_length};
            phcc_pkg::REG_KEY_WORD_0: prdata = r_key_word_0;
            phcc_pkg::REG_KEY_WORD_1: prdata = r_key_word_1;
            phcc_pkg::REG_KEY_WORD_2: prdata = r_key_word_2;
            phcc_pkg::REG_KEY_WORD_3: prdata = r_key_word_3;
            phcc_pkg::REG_KEY_WORD_4: prdata = r_key_word_4;
            default:                  prdata = '0;
        endcase
    end

    assign o_cfg.key_length = r_key_length;
    assign o_cfg.key_words  = {r_key_word_4, r_key_word_3, r_key_word_2,
                               r_key_word_1, r_key_word_0};

endmodule

[src/phcc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phcc_datapath
// item registers, cipher state, key index remainder unit and output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module phcc_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  phcc_pkg::t_cfg                    i_cfg,
    input  phcc_pkg::t_dp_cmd                 i_cmd,
    output phcc_pkg::t_dp_status              o_status,
    input  logic [phcc_pkg::CMD_W-1:0]        i_command,
    input  logic [phcc_pkg::DATA_W-1:0]       i_data_in,
    input  logic [phcc_pkg::POS_W-1:0]        i_byte_index,
    input  logic [phcc_pkg::POS_W-1:0]        i_packet_length,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [phcc_pkg::DATA_W-1:0]       o_data_out,
    output logic                              o_transformed
);

    // captured item
    logic [phcc_pkg::CMD_W-1:0]   r_command;
    logic [phcc_pkg::DATA_W-1:0]  r_data;
    logic [phcc_pkg::POS_W-1:0]   r_pos;
    logic [phcc_pkg::POS_W-1:0]   r_plen;
    logic [phcc_pkg::IDX_W-1:0]   r_rem;
    logic [phcc_pkg::IDX_W-1:0]   n_rem;

    // cipher state
    logic                         r_enabled;
    logic [phcc_pkg::IDX_W-1:0]   r_send_idx;
    logic [phcc_pkg::DATA_W-1:0]  r_send_chain;
    logic [phcc_pkg::IDX_W-1:0]   r_recv_idx;
    logic [phcc_pkg::DATA_W-1:0]  r_recv_chain;

    // output register
    logic                         r_out_valid;
    logic [phcc_pkg::DATA_W-1:0]  r_out_data;
    logic                         r_out_transformed;

    logic [phcc_pkg::IDX_W-1:0]   eff_len;
    logic                         xform_send;
    logic                         xform_recv;
    logic                         xform;
    logic [phcc_pkg::DIV_W-1:0]   rem_wide;
    logic [phcc_pkg::DIV_W-1:0]   len_shifted;
    logic [phcc_pkg::DATA_W-1:0]  key_byte;
    logic [phcc_pkg::DATA_W-1:0]  send_byte;
    logic [phcc_pkg::DATA_W-1:0]  recv_byte;
    logic [phcc_pkg::DATA_W-1:0]  result;
    logic [phcc_pkg::IDX_W-1:0]   idx_next;

    // pick one key byte; the index is below the key length when used
    function automatic logic [phcc_pkg::DATA_W-1:0] pick_key_byte(
        input logic [phcc_pkg::KEY_WORDS-1:0][phcc_pkg::KEY_WORD_W-1:0] words,
        input logic [phcc_pkg::IDX_W-1:0]                               idx
    );
        logic [phcc_pkg::KEY_WORD_W-1:0] word;
        logic [phcc_pkg::WSEL_W-1:0]     wsel;
        logic [phcc_pkg::BSEL_W-1:0]     bsel;
        wsel = idx[phcc_pkg::IDX_W-1 -: phcc_pkg::WSEL_W];
        bsel = idx[phcc_pkg::BSEL_W-1:0];
        case (wsel)
            3'd0:    word = words[0];
            3'd1:    word = words[1];
            3'd2:    word = words[2];
            3'd3:    word = words[3];
            3'd4:    word = words[4];
            default: word = '0;
        endcase
        return word[bsel*phcc_pkg::DATA_W +: phcc_pkg::DATA_W];
    endfunction

    // key length clamped to 1..max
    always_comb begin
        if (i_cfg.key_length == '0) begin
            eff_len = phcc_pkg::IDX_W'(1);
        end else if (i_cfg.key_length > phcc_pkg::IDX_W'(phcc_pkg::MAX_KEY_BYTES)) begin
            eff_len = phcc_pkg::IDX_W'(phcc_pkg::MAX_KEY_BYTES);
        end else begin
            eff_len = i_cfg.key_length;
        end
    end

    // header window checks
    assign xform_send = r_enabled && (r_command == phcc_pkg::CMD_SEND)
                      && (r_plen >= phcc_pkg::SEND_HEADER_BYTES)
                      && (r_pos < phcc_pkg::SEND_HEADER_BYTES);
    assign xform_recv = r_enabled && (r_command == phcc_pkg::CMD_RECV)
                      && (r_plen >= phcc_pkg::RECV_HEADER_BYTES)
                      && (r_pos < phcc_pkg::RECV_HEADER_BYTES);
    assign xform      = xform_send | xform_recv;

    // restoring remainder step
    assign rem_wide    = {{(phcc_pkg::DIV_W-phcc_pkg::IDX_W){1'b0}}, r_rem};
    assign len_shifted = {{(phcc_pkg::DIV_W-phcc_pkg::IDX_W){1'b0}}, eff_len} << i_cmd.mod_shift;

    // byte transform
    assign key_byte  = pick_key_byte(i_cfg.key_words, r_rem);
    assign send_byte = (r_data ^ key_byte) + r_send_chain;
    assign recv_byte = (r_data - r_recv_chain) ^ key_byte;
    assign idx_next  = r_rem + phcc_pkg::IDX_W'(1);

    always_comb begin
        if (xform_send) begin
            result = send_byte;
        end else if (xform_recv) begin
            result = recv_byte;
        end else begin
            result = r_data;
        end
    end

    // key index of the item's direction at capture
    assign n_rem = (i_command == phcc_pkg::CMD_RECV) ? r_recv_idx : r_send_idx;

    // item registers and remainder
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_command <= i_command;
            r_data    <= i_data_in;
            r_pos     <= i_byte_index;
            r_plen    <= i_packet_length;
            r_rem     <= n_rem;
        end else if (i_cmd.mod_step && (rem_wide >= len_shifted)) begin
            r_rem     <= r_rem - len_shifted[phcc_pkg::IDX_W-1:0];
        end
    end

    // cipher state, committed when the result is written out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled    <= 1'b0;
            r_send_idx   <= '0;
            r_send_chain <= '0;
            r_recv_idx   <= '0;
            r_recv_chain <= '0;
        end else if (i_cmd.emit) begin
            if (r_command == phcc_pkg::CMD_RESTART) begin
                r_enabled    <= 1'b1;
                r_send_idx   <= '0;
                r_send_chain <= '0;
                r_recv_idx   <= '0;
                r_recv_chain <= '0;
            end else if (xform_send) begin
                r_send_idx   <= idx_next;
                r_send_chain <= send_byte;
            end else if (xform_recv) begin
                r_recv_idx   <= idx_next;
                r_recv_chain <= r_data;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data        <= result;
            r_out_transformed <= xform;
        end
    end

    assign o_status.need_mod = xform && (r_rem >= eff_len);
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_data_out        = r_out_data;
    assign o_transformed     = r_out_transformed;

    // a transformed item only ever leaves once a restart has enabled the cipher
    `PHCC_ASSERT_IMPL(a_xform_needs_enable, i_clk, i_rst_n, r_out_valid && r_out_transformed, r_enabled, "transformed item while cipher disabled")

endmodule

[src/phcc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phcc_ctrl
// controller: item capture, key index reduction steps and result hand-off
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module phcc_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  phcc_pkg::t_dp_status     i_status,
    output phcc_pkg::t_dp_cmd        o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_MOD  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]                     r_state;
    logic [1:0]                     n_state;
    logic [phcc_pkg::SHIFT_W-1:0]   r_step;
    logic [phcc_pkg::SHIFT_W-1:0]   n_step;

    assign o_in_ready = (r_state == ST_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state         = r_state;
        n_step          = r_step;
        o_cmd.capture   = 1'b0;
        o_cmd.mod_step  = 1'b0;
        o_cmd.mod_shift = r_step;
        o_cmd.emit      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_CALC;
                end
            end
            ST_CALC: begin
                if (i_status.need_mod) begin
                    n_state = ST_MOD;
                    n_step  = phcc_pkg::SHIFT_W'(phcc_pkg::MOD_STEPS - 1);
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (r_step == '0) begin
                    n_state = ST_FIN;
                end else begin
                    n_step = r_step - phcc_pkg::SHIFT_W'(1);
                end
            end
            ST_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // results only go out when the output register can take them
    `PHCC_ASSERT_IMPL(a_emit_needs_slot, i_clk, i_rst_n, o_cmd.emit, i_status.out_free, "result written over a waiting item")
    // after a result is written the controller is free for the next item
    `PHCC_ASSERT_NEXT(a_emit_to_idle, i_clk, i_rst_n, o_cmd.emit, r_state == ST_IDLE, "controller not idle after result")
    // the remainder steps leave the key index below the key length
    `PHCC_ASSERT_IMPL(a_fin_reduced, i_clk, i_rst_n, r_state == ST_FIN, !i_status.need_mod, "key index not reduced")

endmodule

[src/packet_header_chained_cipher_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_header_chained_cipher_unit
// chained xor/add cipher over packet header bytes, send and receive direction
//
//   channel   dir   handshake            payload
//   i_in      in    valid / ready        command, data_in, byte_index, packet_length
//   o_out     out   valid / ready        data_out, transformed
//   apb       in    psel/penable/pready  paddr, pwdata, prdata
//
// an item is accepted in ST_IDLE; when the stored key index is already below the key
// length, ST_CALC writes the output register, else the remainder unit runs one
// restoring step per index bit, 6 steps, in ST_MOD and ST_FIN writes the output
// register
// reset is synchronous; no clearing pass
// one item in work at a time; a new item is accepted while the previous result
// waits in the output register, and the item in work holds until it drains
// ----------------------------------------------------------------------------
module packet_header_chained_cipher_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    phcc_in_if.sink                             i_in,
    phcc_out_if.source                          o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [phcc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [phcc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [phcc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    phcc_pkg::t_cfg        cfg;
    phcc_pkg::t_dp_cmd     dp_cmd;
    phcc_pkg::t_dp_status  dp_status;
    logic                  in_ready;
    logic                  out_valid;
    logic [phcc_pkg::DATA_W-1:0] out_data;
    logic                  out_transformed;

    // configuration registers
    phcc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // controller
    phcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // datapath
    phcc_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .i_command       (i_in.command),
        .i_data_in       (i_in.data_in),
        .i_byte_index    (i_in.byte_index),
        .i_packet_length (i_in.packet_length),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (out_valid),
        .o_data_out      (out_data),
        .o_transformed   (out_transformed)
    );

    // channel hookup
    assign i_in.ready        = in_ready;
    assign o_out.valid       = out_valid;
    assign o_out.data_out    = out_data;
    assign o_out.transformed = out_transformed;

endmodule
